@@ rtl/core/fdtd1d_pkg.sv @@
// Shared types, constants and field arithmetic for the 1-D FDTD engine.
`timescale 1ns / 1ps

package fdtd1d_pkg;

    localparam int CELLS_DEF = 256;
    localparam int FIELD_W   = 24;
    localparam int STEP_W    = 32;
    localparam int IDX_W     = 8;
    localparam int CFG_W     = 8;

    localparam logic [CFG_W-1:0] SOURCE_CELL_RST = CFG_W'(128);

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ
    } t_state;

    // base + floor((a - b) / 2), saturated to the field range
    function automatic logic signed [FIELD_W-1:0] add_half_sat(
        input logic signed [FIELD_W-1:0] base,
        input logic signed [FIELD_W-1:0] a,
        input logic signed [FIELD_W-1:0] b
    );
        logic [FIELD_W:0]              diff;
        logic [FIELD_W:0]              sum;
        logic signed [FIELD_W-1:0]     res;
        diff = {a[FIELD_W-1], a} - {b[FIELD_W-1], b};
        sum  = {base[FIELD_W-1], base} + {diff[FIELD_W], diff[FIELD_W:1]};
        if (sum[FIELD_W] != sum[FIELD_W-1]) begin
            res = sum[FIELD_W] ? FIELD_MIN : FIELD_MAX;
        end else begin
            res = sum[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/fdtd1d_if.sv @@
// Handshake channels for step/read items and read results.
`timescale 1ns / 1ps

interface fdtd1d_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      operation;
    logic signed [fdtd1d_pkg::FIELD_W-1:0]     source_sample;
    logic [fdtd1d_pkg::IDX_W-1:0]              cell_index;

    modport source (output valid, output operation, output source_sample,
                    output cell_index, input ready);
    modport sink   (input valid, input operation, input source_sample,
                    input cell_index, output ready);
endinterface

interface fdtd1d_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [fdtd1d_pkg::FIELD_W-1:0]     electric_value;
    logic signed [fdtd1d_pkg::FIELD_W-1:0]     magnetic_value;
    logic [fdtd1d_pkg::STEP_W-1:0]             steps_done;

    modport source (output valid, output electric_value, output magnetic_value,
                    output steps_done, input ready);
    modport sink   (input valid, input electric_value, input magnetic_value,
                    input steps_done, output ready);
endinterface

@@ rtl/core/fdtd1d_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module fdtd1d_ram #(
    parameter int WIDTH = fdtd1d_pkg::FIELD_W,
    parameter int DEPTH = fdtd1d_pkg::CELLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/fdtd_1d_free_space_engine.sv @@
// Top level of the 1-D free-space FDTD engine.
`timescale 1ns / 1ps
//
// Input channel i_in carries items: operation step advances the grid one time
// step using source_sample; operation read returns both fields of cell_index
// and the step count on o_out. Both channels transfer when valid and ready
// are high at a rising edge. i_cfg_we/i_cfg_wdata write the source cell.
//
// The fields sit in two RAMs (electric, magnetic) with registered read. A step
// sweeps the grid once, one cell per cycle: a cell's electric update and the
// previous cell's magnetic update run in a two-stage pipeline behind the read.
// A step occupies the block until the pipeline drains; a read loads its result
// into the output register once that register is free. One item is worked at a
// time; i_in.ready is high whenever the block is idle.
//
// After reset a clearing pass writes zero into every cell, with i_in.ready low;
// the source cell returns to 128 and the step count to zero.
// When the receiver stalls, a finished result waits in the output register
// and the block still takes step items; a second read holds until the first
// result is transferred.

module fdtd_1d_free_space_engine #(
    parameter int CELLS = fdtd1d_pkg::CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fdtd1d_pkg::CFG_W-1:0]   i_cfg_wdata,
    fdtd1d_in_if.sink                      i_in,
    fdtd1d_out_if.source                   o_out
);

    localparam int FW    = fdtd1d_pkg::FIELD_W;
    localparam int SW    = fdtd1d_pkg::STEP_W;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = AW + 1;
    localparam int CW    = ((AW > fdtd1d_pkg::IDX_W) ? AW : fdtd1d_pkg::IDX_W) + 1;

    fdtd1d_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]               r_cnt;
    logic                           cnt_last;
    logic [fdtd1d_pkg::CFG_W-1:0]   r_source_cell;
    logic [fdtd1d_pkg::STEP_W-1:0]  r_steps;
    logic signed [FW-1:0]           r_sample;
    logic [AW-1:0]                  r_rd_addr;
    logic                           r_rd_oob;

    logic                           step_acc;
    logic                           read_acc;
    logic [CW-1:0]                  in_idx_ext;
    logic [AW-1:0]                  in_idx;
    logic                           in_range;

    logic [AW-1:0]                  rd_addr;
    logic                           out_load;

    logic                           e_we, h_we;
    logic [AW-1:0]                  e_waddr, h_waddr;
    logic signed [FW-1:0]           e_wdata, h_wdata;
    logic signed [FW-1:0]           e_rdata, h_rdata;

    logic                           r_s1_vld, r_s2_vld;
    logic [AW-1:0]                  r_s1_idx, r_s2_idx;
    logic signed [FW-1:0]           r_s2_e, r_s2_h, r_s3_e, r_s3_h;
    logic signed [FW-1:0]           e_upd, e_new, h_new;
    logic                           src_hit;

    logic                           r_out_vld;
    logic signed [FW-1:0]           r_out_e, r_out_h;
    logic [fdtd1d_pkg::STEP_W-1:0]  r_out_steps;

    // ---------------------------------------------------------------- input
    assign i_in.ready = (r_state == fdtd1d_pkg::ST_IDLE);
    assign step_acc   = i_in.valid && i_in.ready && (i_in.operation == fdtd1d_pkg::OP_STEP);
    assign read_acc   = i_in.valid && i_in.ready && (i_in.operation == fdtd1d_pkg::OP_READ);
    assign in_idx_ext = CW'(i_in.cell_index);
    assign in_idx     = in_idx_ext[AW-1:0];
    assign in_range   = (in_idx_ext < CW'(CELLS));
    assign cnt_last   = (r_cnt == CNT_W'(CELLS - 1));

    // ---------------------------------------------------------------- fsm
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fdtd1d_pkg::ST_CLEAR: begin
                if (cnt_last) n_state = fdtd1d_pkg::ST_IDLE;
            end
            fdtd1d_pkg::ST_IDLE: begin
                if (step_acc) begin
                    n_state = fdtd1d_pkg::ST_SWEEP;
                end else if (read_acc) begin
                    n_state = fdtd1d_pkg::ST_READ;
                end
            end
            fdtd1d_pkg::ST_SWEEP: begin
                if (cnt_last) n_state = fdtd1d_pkg::ST_DRAIN;
            end
            fdtd1d_pkg::ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) n_state = fdtd1d_pkg::ST_IDLE;
            end
            fdtd1d_pkg::ST_READ: begin
                if (!r_out_vld || o_out.ready) n_state = fdtd1d_pkg::ST_IDLE;
            end
            default: n_state = fdtd1d_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        rd_addr  = r_cnt[AW-1:0];
        out_load = 1'b0;
        unique case (r_state)
            fdtd1d_pkg::ST_IDLE: rd_addr = in_idx;
            fdtd1d_pkg::ST_READ: begin
                rd_addr  = r_rd_addr;
                out_load = !r_out_vld || o_out.ready;
            end
            default: rd_addr = r_cnt[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fdtd1d_pkg::ST_CLEAR;
            r_cnt         <= '0;
            r_source_cell <= fdtd1d_pkg::SOURCE_CELL_RST;
            r_steps       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == fdtd1d_pkg::ST_CLEAR || r_state == fdtd1d_pkg::ST_SWEEP) begin
                r_cnt <= cnt_last ? '0 : r_cnt + CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_source_cell <= i_cfg_wdata;
            end
            if (step_acc) begin
                r_steps <= r_steps + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_acc) begin
            r_sample <= i_in.source_sample;
        end
        if (read_acc) begin
            r_rd_addr <= in_idx;
            r_rd_oob  <= !in_range;
        end
    end

    // ---------------------------------------------------------------- sweep pipeline
    // stage 1: electric update of cell j from old H[j-1], H[j]; cell 0 holds, the source cell takes the sample
    assign e_upd   = fdtd1d_pkg::add_half_sat(e_rdata, r_s2_h, h_rdata);
    assign src_hit = (CW'(r_source_cell) == CW'(r_s1_idx));
    always_comb begin
        if (src_hit) begin
            e_new = r_sample;
        end else if (r_s1_idx == '0) begin
            e_new = e_rdata;
        end else begin
            e_new = e_upd;
        end
    end

    // stage 2: magnetic update of cell j-1 from new E[j-1], E[j]
    assign h_new = fdtd1d_pkg::add_half_sat(r_s3_h, r_s3_e, r_s2_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == fdtd1d_pkg::ST_SWEEP);
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_cnt[AW-1:0];
        if (r_s1_vld) begin
            r_s2_idx <= r_s1_idx;
            r_s2_e   <= e_new;
            r_s2_h   <= h_rdata;
        end
        if (r_s2_vld) begin
            r_s3_e <= r_s2_e;
            r_s3_h <= r_s2_h;
        end
    end

    // ---------------------------------------------------------------- memories
    always_comb begin
        if (r_state == fdtd1d_pkg::ST_CLEAR) begin
            e_we    = 1'b1;
            e_waddr = r_cnt[AW-1:0];
            e_wdata = '0;
            h_we    = 1'b1;
            h_waddr = r_cnt[AW-1:0];
            h_wdata = '0;
        end else begin
            e_we    = r_s1_vld;
            e_waddr = r_s1_idx;
            e_wdata = e_new;
            h_we    = r_s2_vld && (r_s2_idx != '0);
            h_waddr = r_s2_idx - AW'(1);
            h_wdata = h_new;
        end
    end

    fdtd1d_ram #(
        .WIDTH (FW),
        .DEPTH (CELLS)
    ) u_e_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (rd_addr),
        .o_rdata (e_rdata)
    );

    fdtd1d_ram #(
        .WIDTH (FW),
        .DEPTH (CELLS)
    ) u_h_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (rd_addr),
        .o_rdata (h_rdata)
    );

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_e     <= r_rd_oob ? '0 : e_rdata;
            r_out_h     <= r_rd_oob ? '0 : h_rdata;
            r_out_steps <= r_steps;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.electric_value = r_out_e;
    assign o_out.magnetic_value = r_out_h;
    assign o_out.steps_done     = r_out_steps;

    // ---------------------------------------------------------------- checks
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fdtd1d_pkg::ST_IDLE) |-> (!e_we && !h_we))
        else $error("memory write while idle");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> $past(r_s1_vld))
        else $error("stage 2 valid without stage 1");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !$past(r_out_vld)) |-> ($past(r_state) == fdtd1d_pkg::ST_READ))
        else $error("result loaded outside a read");

    a_steps_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_steps != $past(r_steps))) |-> $past(step_acc))
        else $error("step count moved without a step transfer");

endmodule
